[hdl/slpd_pkg.sv]
// Shared types and constants for the segmented length-prefix deframer.
package slpd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;

	// Payload length of a continuation segment (length code 0)
	localparam logic [BYTE_W-1:0] MAX_SEGMENT = 8'd255;
	localparam logic [BYTE_W-1:0] CONT_CODE   = 8'd0;
	localparam logic [LEN_W-1:0]  MAX_MSG_LEN_RESET = 16'd1199;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              dropped;
		logic              end_of_message;
		logic [LEN_W-1:0]  message_length;
		logic              truncated;
	} result_t;

endpackage

[hdl/slpd_in_reg.sv]
// Input register stage: holds one stream byte until the core takes it.
module slpd_in_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [slpd_pkg::BYTE_W-1:0] in_byte,
	input  logic                        take,
	output logic                        valid_s1,
	output logic [slpd_pkg::BYTE_W-1:0] byte_s1
);

	logic load;

	assign in_ready = !valid_s1 || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

[hdl/slpd_core.sv]
// Deframer core: segment state, capacity register and per-byte result logic.
module slpd_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [slpd_pkg::LEN_W-1:0]  cfg_data,
	input  logic                        valid_s1,
	input  logic [slpd_pkg::BYTE_W-1:0] byte_s1,
	input  logic                        out_free,
	output logic                        take,
	output logic                        res_valid,
	output slpd_pkg::result_t           res
);

	logic [slpd_pkg::LEN_W-1:0]  max_msg_len_q;
	logic                        in_payload_q;
	logic [slpd_pkg::BYTE_W-1:0] bytes_left_q;
	logic                        final_q;
	logic [slpd_pkg::LEN_W-1:0]  kept_q;
	logic                        ovf_q;

	logic                        keep;
	logic [slpd_pkg::LEN_W-1:0]  kept_n;
	logic [slpd_pkg::BYTE_W-1:0] left_n;
	logic                        seg_done;
	logic                        last;

	// Length bytes need no output slot; payload bytes wait for one
	assign take      = valid_s1 && (!in_payload_q || out_free);
	assign res_valid = take && in_payload_q;

	always_comb begin
		keep     = kept_q < max_msg_len_q;
		kept_n   = keep ? kept_q + 16'd1 : kept_q;
		left_n   = bytes_left_q - 8'd1;
		seg_done = left_n == 8'd0;
		last     = seg_done && final_q;

		res.data_byte      = byte_s1;
		res.dropped        = !keep;
		res.end_of_message = last;
		res.message_length = last ? kept_n : '0;
		res.truncated      = last && (ovf_q || !keep);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_len_q <= slpd_pkg::MAX_MSG_LEN_RESET;
		end else if (cfg_valid) begin
			max_msg_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			bytes_left_q <= '0;
			final_q      <= 1'b0;
			kept_q       <= '0;
			ovf_q        <= 1'b0;
		end else if (take) begin
			if (!in_payload_q) begin
				in_payload_q <= 1'b1;
				if (byte_s1 == slpd_pkg::CONT_CODE) begin
					bytes_left_q <= slpd_pkg::MAX_SEGMENT;
					final_q      <= 1'b0;
				end else begin
					bytes_left_q <= byte_s1;
					final_q      <= 1'b1;
				end
			end else begin
				bytes_left_q <= left_n;
				if (seg_done) begin
					in_payload_q <= 1'b0;
				end
				if (last) begin
					kept_q  <= '0;
					ovf_q   <= 1'b0;
					final_q <= 1'b0;
				end else begin
					kept_q <= kept_n;
					ovf_q  <= ovf_q || !keep;
				end
			end
		end
	end

endmodule

[hdl/slpd_out_reg.sv]
// Result register: holds one result beat until the receiver takes it.
module slpd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  slpd_pkg::result_t res,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              out_free,
	output slpd_pkg::result_t res_q
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_valid) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

[hdl/segmented_length_prefix_deframer_top.sv]
// Top level of the segmented length-prefix deframer.
//
// Input channel (in_valid/in_ready/in_byte) carries one stream byte per beat.
// A message is a chain of segments: a length byte, then its payload. Code 0
// opens a 255-byte segment with more to follow; code n > 0 opens the final
// segment of n bytes. Length bytes give no output beat.
// Output channel (out_valid/out_ready) carries one beat per payload byte:
// data_byte, dropped, and on the last byte end_of_message, message_length and
// truncated. Bytes beyond the capacity are marked dropped and not counted.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the capacity
// max_msg_len; cfg_ready is always high. Write it only while idle.
// Path: an accepted input beat loads the input register; the core then passes
// a payload byte through its combinational logic into the result register.
// Throughput: one byte per cycle while payload bytes find the result register
// free, set by the state update in the core between the two registers.
// Reset clears all segment state and both valid flags, and loads capacity 1199.
// When the receiver stalls, the result register holds its beat; one more byte
// waits in the input register, and in_ready drops only when both are full
// and the waiting byte is payload.
module segmented_length_prefix_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        dropped,
	output logic        end_of_message,
	output logic [15:0] message_length,
	output logic        truncated
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              take;
	logic              out_free;
	logic              res_valid;
	slpd_pkg::result_t res;
	slpd_pkg::result_t res_q;

	// Capacity register takes every write at once
	assign cfg_ready = 1'b1;

	slpd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	slpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.out_free  (out_free),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	slpd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_free  (out_free),
		.res_q     (res_q)
	);

	// Unpack the held result onto the output ports
	assign data_byte      = res_q.data_byte;
	assign dropped        = res_q.dropped;
	assign end_of_message = res_q.end_of_message;
	assign message_length = res_q.message_length;
	assign truncated      = res_q.truncated;

endmodule

[hdl/slpd_checker.sv]
// Port-level checker for the deframer, bound to the top level.
module slpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  data_byte,
	input logic        dropped,
	input logic        end_of_message,
	input logic [15:0] message_length,
	input logic        truncated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte)
			&& $stable(end_of_message) && $stable(message_length))
		else $error("output beat changed while stalled");

	a_mid_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_message |-> message_length == 16'd0 && !truncated)
		else $error("end fields set on a byte that is not the message end");

	a_drop_truncates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_message && dropped |-> truncated)
		else $error("dropped last byte without truncated flag");

	a_kept_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_message && !dropped |-> message_length != 16'd0)
		else $error("kept last byte with zero message length");

endmodule

bind segmented_length_prefix_deframer_top slpd_checker u_slpd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.data_byte      (data_byte),
	.dropped        (dropped),
	.end_of_message (end_of_message),
	.message_length (message_length),
	.truncated      (truncated)
);

[test/segmented_length_prefix_deframer_top_tb.sv]
// Self-checking testbench for the segmented length-prefix deframer top level.
module segmented_length_prefix_deframer_top_tb;

	// Hard stop for a hung run; far above the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	// Idle wait after the owed beats are out, before a capacity write
	localparam int SETTLE_CYCLES = 4;
	localparam int BYTES_PER_PHASE = 175;
	localparam int NUM_PHASES = 8;

	// Tracks the deframer state and holds the payload beats still due on the output.
	class payload_tracker;
		logic [slpd_pkg::LEN_W-1:0]  capacity;
		logic                        in_payload;
		logic [slpd_pkg::BYTE_W-1:0] seg_left;
		logic                        seg_final;
		logic [slpd_pkg::LEN_W-1:0]  kept;
		logic                        overflow;
		slpd_pkg::result_t           payload_due[$];
		int errors;
		int n_bytes;
		int n_beats;
		int n_messages;
		int n_truncated;
		int n_dropped;
		int n_cap_writes;

		function new();
			capacity = slpd_pkg::MAX_MSG_LEN_RESET;
			in_payload = 1'b0;
			seg_left = '0;
			seg_final = 1'b0;
			kept = '0;
			overflow = 1'b0;
			errors = 0;
			n_bytes = 0;
			n_beats = 0;
			n_messages = 0;
			n_truncated = 0;
			n_dropped = 0;
			n_cap_writes = 0;
		endfunction

		function void set_capacity(logic [slpd_pkg::LEN_W-1:0] value);
			capacity = value;
			n_cap_writes++;
		endfunction

		// Advance the segment state by one accepted stream byte.
		function void take_stream_byte(logic [slpd_pkg::BYTE_W-1:0] b);
			slpd_pkg::result_t r;
			n_bytes++;
			if (!in_payload) begin
				// Length byte: code 0 opens a full continuation segment
				if (b == slpd_pkg::CONT_CODE) begin
					seg_left = slpd_pkg::MAX_SEGMENT;
					seg_final = 1'b0;
				end else begin
					seg_left = b;
					seg_final = 1'b1;
				end
				in_payload = 1'b1;
				return;
			end
			r = '0;
			r.data_byte = b;
			if (kept < capacity) begin
				kept = kept + 1'b1;
			end else begin
				overflow = 1'b1;
				r.dropped = 1'b1;
			end
			seg_left = seg_left - 1'b1;
			if (seg_left == '0) begin
				in_payload = 1'b0;
				if (seg_final) begin
					r.end_of_message = 1'b1;
					r.message_length = kept;
					r.truncated = overflow;
					kept = '0;
					overflow = 1'b0;
					seg_final = 1'b0;
				end
			end
			payload_due.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at beat %0d: %s", n_beats, msg);
			errors++;
		endtask

		task check_field(string name, int got, int want);
			if (got != want)
				report($sformatf("%s got %0h, want %0h", name, got, want));
		endtask

		task check_payload_beat(slpd_pkg::result_t got);
			slpd_pkg::result_t want;
			if (payload_due.size() == 0) begin
				report($sformatf("unexpected beat, data_byte %0h", got.data_byte));
				return;
			end
			want = payload_due.pop_front();
			check_field("data_byte", got.data_byte, want.data_byte);
			check_field("dropped", got.dropped, want.dropped);
			check_field("end_of_message", got.end_of_message, want.end_of_message);
			check_field("message_length", got.message_length, want.message_length);
			check_field("truncated", got.truncated, want.truncated);
			n_beats++;
			if (want.dropped)
				n_dropped++;
			if (want.end_of_message) begin
				n_messages++;
				if (want.truncated)
					n_truncated++;
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  data_byte;
	logic        dropped;
	logic        end_of_message;
	logic [15:0] message_length;
	logic        truncated;

	payload_tracker tracker;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;
	// Bytes still owed to the payload of the segment being generated
	int gen_left = 0;

	segmented_length_prefix_deframer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_byte      (data_byte),
		.dropped        (dropped),
		.end_of_message (end_of_message),
		.message_length (message_length),
		.truncated      (truncated)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: check each accepted beat, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_payload_beat({data_byte, dropped, end_of_message,
				message_length, truncated});
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: end a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Next byte of a well-formed stream: length codes with random payload.
	// Mostly short final segments so that capacity limits are hit often, with
	// occasional continuation chains and full 255-byte final segments.
	function logic [7:0] next_stream_byte();
		int pick;
		int len;
		pick = $urandom_range(99);
		if (gen_left == 0) begin
			if (pick < 5) begin
				gen_left = 255;
				return slpd_pkg::CONT_CODE;
			end else if (pick < 62) begin
				len = $urandom_range(8, 1);
			end else if (pick < 90) begin
				len = $urandom_range(40, 9);
			end else if (pick < 97) begin
				len = $urandom_range(254, 41);
			end else begin
				len = 255;
			end
			gen_left = len;
			return len[7:0];
		end
		gen_left--;
		if (pick < 10)
			return 8'h00;
		if (pick < 20)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// Offer one byte after a random gap; hold it until accepted.
	task send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_stream_byte(b);
	endtask

	// Drop valid and wait until every owed beat has come out, then settle.
	task drain();
		in_valid <= 1'b0;
		while (tracker.payload_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the capacity register; only called while the block is idle.
	task write_capacity(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_capacity(value);
		cfg_valid <= 1'b0;
	endtask

	task set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 72;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 72;
			end
			default: begin
				send_idle_pct = 11;
				recv_stall_pct = 11;
			end
		endcase
	endtask

	initial begin
		logic [15:0] cap;
		tracker = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_byte <= '0;
		out_ready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity: single-byte messages with the
		// extreme payload values, then a short three-byte message.
		send_byte(8'd1);
		send_byte(8'h00);
		send_byte(8'd1);
		send_byte(8'hFF);
		send_byte(8'd3);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h01);

		// Zero capacity: every byte dropped, length 0, truncated.
		write_capacity(16'd0);
		send_byte(8'd2);
		send_byte(8'h80);
		send_byte(8'h7F);

		// Capacity below message size: tail bytes dropped.
		write_capacity(16'd2);
		send_byte(8'd4);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);
		send_byte(8'h78);

		// Lower the capacity mid-message: the two kept bytes stay counted.
		write_capacity(16'd3);
		send_byte(8'd5);
		send_byte(8'h11);
		send_byte(8'h22);
		write_capacity(16'd1);
		send_byte(8'h33);
		send_byte(8'h44);
		send_byte(8'h88);

		// Random phases; boundaries land anywhere in the stream, so capacity
		// changes also fall inside messages and continuation chains.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: cap = slpd_pkg::MAX_MSG_LEN_RESET;
				1: cap = 16'd0;
				2: cap = 16'hFFFF;
				3: cap = 16'd1;
				4: cap = 16'($urandom_range(40, 2));
				default: cap = 16'($urandom_range(300, 2));
			endcase
			write_capacity(cap);
			set_idling(ph % 4);
			repeat (BYTES_PER_PHASE) send_byte(next_stream_byte());
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d stream bytes, %0d payload beats, %0d messages ended",
			tracker.n_bytes, tracker.n_beats, tracker.n_messages);
		$display("  %0d truncated messages, %0d dropped bytes, %0d capacity writes",
			tracker.n_truncated, tracker.n_dropped, tracker.n_cap_writes);
		if (tracker.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
